// ----- rtl/mpfc_pkg.sv -----
// Shared types and constants for the multirate polyphase FIR chain.
// No dependencies.
`timescale 1ns / 1ps

package mpfc_pkg;

   localparam int NUM_PHASES  = 4;
   localparam int KERNEL_BANK = 4;
   localparam int ACC_WIDTH   = 32;
   localparam int IO_WIDTH    = 16;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // decimator phase to coefficient bank
   function automatic logic [1:0] decim_bank(input logic [1:0] ph);
      logic [1:0] b;
      case (ph)
         2'd0: b = 2'd0;
         2'd1: b = 2'd3;
         2'd2: b = 2'd2;
         2'd3: b = 2'd1;
         default: b = 2'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/mpfc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mpfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mpfc_mac.sv -----
// Shared multiply-accumulate unit: product register, Q1.31 accumulator.
// Depends on mpfc_pkg.
`timescale 1ns / 1ps

module mpfc_mac import mpfc_pkg::*; #(
   parameter int DATA_WIDTH = 16,
   parameter int COEF_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mac_ctl_type                  ctl,
   input  logic signed [DATA_WIDTH-1:0] sample,
   input  logic signed [COEF_WIDTH-1:0] coef,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] result
);

   localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
   localparam int SH     = ACC_WIDTH + 1 - PROD_W;
   localparam int SHL    = (SH > 0) ? SH : 0;
   localparam int SHR    = (SH < 0) ? -SH : 0;

   mac_ctl_type s1_ff, s2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [63:0]       prod_ext;
   logic [ACC_WIDTH-1:0]     acc_ff, acc_in, term;
   logic                     done_ff;

   assign prod_in  = sample * coef;
   assign prod_ext = 64'(prod_ff);
   assign term     = ACC_WIDTH'((prod_ext <<< SHL) >>> SHR);
   assign acc_in   = s2_ff.first ? term : acc_ff + term;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= ctl;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff.valid & s2_ff.last;
      end
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff[ACC_WIDTH-1 -: DATA_WIDTH];

endmodule

// ----- rtl/multirate_polyphase_fir_chain.sv -----
// Polyphase decimate-by-4, kernel FIR, interpolate-by-4 chain on one shared MAC.
// Coefficient word: taken while idle, and the block stays idle. Sample word: a decimator
// pass and an interpolator pass on the MAC, with a kernel pass between them at decimator
// phase 0; no further word is taken until they are done. A result word still stalled
// when the next one finishes holds the block until it is taken. Reset: synchronous;
// then the delay lines are zeroed, and no word is taken until that is done.
`timescale 1ns / 1ps

module multirate_polyphase_fir_chain import mpfc_pkg::*; #(
   parameter int PHASE_TAPS  = 32,
   parameter int KERNEL_TAPS = 64,
   parameter int DATA_WIDTH  = 16,
   parameter int COEF_WIDTH  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [15:0] req_data_word,
   input  logic [2:0]         req_coef_bank,
   input  logic [5:0]         req_coef_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample
);

   localparam int LINE_DEPTH = NUM_PHASES * PHASE_TAPS;
   localparam int COEF_DEPTH = LINE_DEPTH + KERNEL_TAPS;
   localparam int MAX_TAPS   = (PHASE_TAPS > KERNEL_TAPS) ? PHASE_TAPS : KERNEL_TAPS;
   localparam int CLR_DEPTH  = (LINE_DEPTH > KERNEL_TAPS) ? LINE_DEPTH : KERNEL_TAPS;
   localparam int LA_W       = $clog2(LINE_DEPTH);
   localparam int KA_W       = $clog2(KERNEL_TAPS);
   localparam int CA_W       = $clog2(COEF_DEPTH);
   localparam int PT_W       = $clog2(PHASE_TAPS);
   localparam int CNT_W      = $clog2(MAX_TAPS) + 1;
   localparam int CLR_W      = $clog2(CLR_DEPTH);
   localparam int X_SHL      = (DATA_WIDTH >= IO_WIDTH) ? DATA_WIDTH - IO_WIDTH : 0;
   localparam int X_SHR      = (DATA_WIDTH <  IO_WIDTH) ? IO_WIDTH - DATA_WIDTH : 0;
   localparam int C_SHL      = (COEF_WIDTH >= IO_WIDTH) ? COEF_WIDTH - IO_WIDTH : 0;
   localparam int C_SHR      = (COEF_WIDTH <  IO_WIDTH) ? IO_WIDTH - COEF_WIDTH : 0;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_ISSUE, ST_DRAIN, ST_HOLD} state_type;
   typedef enum logic [1:0] {PASS_DEC, PASS_KER, PASS_INT} pass_type;

   state_type state_ff;
   pass_type  pass_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CLR_W-1:0] clr_ff;
   logic [1:0]       dph_ff, iph_ff;
   logic [PT_W-1:0]  dptr_ff, iptr_ff;
   logic [KA_W-1:0]  kptr_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, hk_ff;
   logic signed [DATA_WIDTH-1:0] hp_ff [3];
   logic [15:0]      out_hold_ff;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_out_sample_ff;
   logic             first_d_ff;

   logic req_take, clearing, issuing, pass_first, pass_last, mac_done, rsp_load;
   logic [CNT_W-1:0] n_taps, sel_ptr, off;
   logic signed [DATA_WIDTH-1:0] x_conv, mac_result, mac_sample, dsum, r_x4;
   logic signed [COEF_WIDTH-1:0] c_conv, coef_rdata;
   logic [15:0] o_conv;
   logic [LA_W-1:0] dec_base, int_base;
   logic [CA_W-1:0] coef_raddr, coef_waddr;
   logic            coef_we;
   logic [LA_W-1:0] dline_waddr, dline_raddr, iline_waddr, iline_raddr;
   logic [KA_W-1:0] kline_waddr;
   logic            dline_we, iline_we, kline_we;
   logic [DATA_WIDTH-1:0] dline_wdata, iline_wdata, kline_wdata;
   logic [DATA_WIDTH-1:0] dline_rdata, iline_rdata, kline_rdata;
   mac_ctl_type     mac_ctl;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign clearing  = (state_ff == ST_CLEAR);
   assign issuing   = (state_ff == ST_ISSUE);

   assign x_conv = DATA_WIDTH'((32'(req_data_word) <<< X_SHL) >>> X_SHR);
   assign c_conv = COEF_WIDTH'((32'(req_data_word) <<< C_SHL) >>> C_SHR);

   // circular addressing: tap i reads slot (ptr - i) mod n
   assign n_taps     = (pass_ff == PASS_KER) ? CNT_W'(KERNEL_TAPS) : CNT_W'(PHASE_TAPS);
   assign pass_first = (cnt_ff == '0);
   assign pass_last  = (cnt_ff == n_taps - CNT_W'(1));
   always_comb begin
      case (pass_ff)
         PASS_DEC: sel_ptr = CNT_W'(dptr_ff);
         PASS_KER: sel_ptr = CNT_W'(kptr_ff);
         PASS_INT: sel_ptr = CNT_W'(iptr_ff);
         default:  sel_ptr = '0;
      endcase
   end
   assign off = (sel_ptr >= cnt_ff) ? sel_ptr - cnt_ff : sel_ptr + n_taps - cnt_ff;

   assign dec_base = LA_W'(32'(dph_ff) * PHASE_TAPS);
   assign int_base = LA_W'(32'(iph_ff) * PHASE_TAPS);

   always_comb begin
      case (pass_ff)
         PASS_DEC: coef_raddr = CA_W'(32'(decim_bank(dph_ff)) * PHASE_TAPS + 32'(cnt_ff));
         PASS_KER: coef_raddr = CA_W'(LINE_DEPTH + 32'(cnt_ff));
         PASS_INT: coef_raddr = CA_W'(32'(iph_ff) * PHASE_TAPS + 32'(cnt_ff));
         default:  coef_raddr = '0;
      endcase
   end

   always_comb begin
      coef_we    = 1'b0;
      coef_waddr = '0;
      if (req_take && req_opcode == OP_COEF) begin
         if (32'(req_coef_bank) < NUM_PHASES && 32'(req_coef_index) < PHASE_TAPS) begin
            coef_we    = 1'b1;
            coef_waddr = CA_W'(32'(req_coef_bank) * PHASE_TAPS + 32'(req_coef_index));
         end else if (32'(req_coef_bank) == KERNEL_BANK &&
                      32'(req_coef_index) < KERNEL_TAPS) begin
            coef_we    = 1'b1;
            coef_waddr = CA_W'(LINE_DEPTH + 32'(req_coef_index));
         end
      end
   end

   assign dline_we    = (clearing && 32'(clr_ff) < LINE_DEPTH) ||
                        (issuing && pass_ff == PASS_DEC && pass_first);
   assign dline_waddr = clearing ? LA_W'(clr_ff) : dec_base + LA_W'(dptr_ff);
   assign dline_wdata = clearing ? '0 : x_ff;
   assign dline_raddr = dec_base + LA_W'(off);

   assign iline_we    = (clearing && 32'(clr_ff) < LINE_DEPTH) ||
                        (issuing && pass_ff == PASS_INT && pass_first);
   assign iline_waddr = clearing ? LA_W'(clr_ff) : int_base + LA_W'(iptr_ff);
   assign iline_wdata = clearing ? '0 : x_ff;
   assign iline_raddr = int_base + LA_W'(off);

   assign kline_we    = (clearing && 32'(clr_ff) < KERNEL_TAPS) ||
                        (issuing && pass_ff == PASS_KER && pass_first);
   assign kline_waddr = clearing ? KA_W'(clr_ff) : kptr_ff;
   assign kline_wdata = clearing ? '0 : x_ff;

   mpfc_ram #(.WIDTH(COEF_WIDTH), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock(clock), .we(coef_we), .waddr(coef_waddr), .wdata(c_conv),
      .raddr(coef_raddr), .rdata(coef_rdata)
   );
   mpfc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LINE_DEPTH)) u_dline_ram (
      .clock(clock), .we(dline_we), .waddr(dline_waddr), .wdata(dline_wdata),
      .raddr(dline_raddr), .rdata(dline_rdata)
   );
   mpfc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LINE_DEPTH)) u_iline_ram (
      .clock(clock), .we(iline_we), .waddr(iline_waddr), .wdata(iline_wdata),
      .raddr(iline_raddr), .rdata(iline_rdata)
   );
   mpfc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(KERNEL_TAPS)) u_kline_ram (
      .clock(clock), .we(kline_we), .waddr(kline_waddr), .wdata(kline_wdata),
      .raddr(KA_W'(off)), .rdata(kline_rdata)
   );

   // newest tap comes from x_ff, the memory still holds the old slot
   always_comb begin
      if (first_d_ff) begin
         mac_sample = x_ff;
      end else begin
         case (pass_ff)
            PASS_DEC: mac_sample = dline_rdata;
            PASS_KER: mac_sample = kline_rdata;
            PASS_INT: mac_sample = iline_rdata;
            default:  mac_sample = '0;
         endcase
      end
   end

   assign mac_ctl.valid = issuing;
   assign mac_ctl.first = issuing & pass_first;
   assign mac_ctl.last  = issuing & pass_last;

   mpfc_mac #(.DATA_WIDTH(DATA_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_mac (
      .clock(clock), .reset(reset), .ctl(mac_ctl), .sample(mac_sample),
      .coef(coef_rdata), .done(mac_done), .result(mac_result)
   );

   assign dsum   = mac_result + hp_ff[0] + hp_ff[1] + hp_ff[2];
   assign r_x4   = mac_result <<< 2;
   assign o_conv = 16'((32'(r_x4) <<< X_SHR) >>> X_SHL);

   assign rsp_load = ~(rsp_valid_ff & rsp_stall) &
                     ((state_ff == ST_DRAIN && mac_done && pass_ff == PASS_INT) ||
                      state_ff == ST_HOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pass_ff      <= PASS_DEC;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         dph_ff       <= '0;
         iph_ff       <= '0;
         dptr_ff      <= '0;
         iptr_ff      <= '0;
         kptr_ff      <= '0;
         hp_ff[0]     <= '0;
         hp_ff[1]     <= '0;
         hp_ff[2]     <= '0;
         hk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         first_d_ff   <= 1'b0;
      end else begin
         first_d_ff <= issuing & pass_first;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (32'(clr_ff) == CLR_DEPTH - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_take && req_opcode == OP_SAMPLE) begin
                  x_ff     <= x_conv;
                  pass_ff  <= PASS_DEC;
                  cnt_ff   <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (pass_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  case (pass_ff)
                     PASS_DEC: begin
                        dph_ff <= dph_ff + 2'd1;
                        if (dph_ff == 2'd3) begin
                           dptr_ff <= (32'(dptr_ff) == PHASE_TAPS - 1) ? '0 :
                                      dptr_ff + PT_W'(1);
                        end
                        case (dph_ff)
                           2'd1:    hp_ff[0] <= mac_result;
                           2'd2:    hp_ff[1] <= mac_result;
                           2'd3:    hp_ff[2] <= mac_result;
                           default: ;
                        endcase
                        if (dph_ff == 2'd0) begin
                           x_ff    <= dsum;
                           pass_ff <= PASS_KER;
                        end else begin
                           x_ff    <= hk_ff;
                           pass_ff <= PASS_INT;
                        end
                        state_ff <= ST_ISSUE;
                     end
                     PASS_KER: begin
                        hk_ff    <= mac_result;
                        x_ff     <= mac_result;
                        kptr_ff  <= (32'(kptr_ff) == KERNEL_TAPS - 1) ? '0 :
                                    kptr_ff + KA_W'(1);
                        pass_ff  <= PASS_INT;
                        state_ff <= ST_ISSUE;
                     end
                     default: begin
                        iph_ff <= iph_ff + 2'd1;
                        if (iph_ff == 2'd3) begin
                           iptr_ff <= (32'(iptr_ff) == PHASE_TAPS - 1) ? '0 :
                                      iptr_ff + PT_W'(1);
                        end
                        if (rsp_valid_ff && rsp_stall) begin
                           out_hold_ff <= o_conv;
                           state_ff    <= ST_HOLD;
                        end else begin
                           rsp_out_sample_ff <= o_conv;
                           state_ff          <= ST_IDLE;
                        end
                     end
                  endcase
               end
            end
            ST_HOLD: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_out_sample_ff <= out_hold_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;

endmodule

// ----- rtl/mpfc_chk.sv -----
// Port-level checks for the multirate polyphase FIR chain, bound to the top level.
// Depends on multirate_polyphase_fir_chain.
`timescale 1ns / 1ps

module mpfc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic [15:0] req_data_word,
   input logic [2:0]  req_coef_bank,
   input logic [5:0]  req_coef_index,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_sample
);

   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("not busy after reset");

   a_coef_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode |=> !req_stall)
      else $error("coefficient word left the block busy");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_opcode |=> req_stall)
      else $error("sample word did not start work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample))
      else $error("stalled result word changed");

endmodule

bind multirate_polyphase_fir_chain mpfc_chk u_mpfc_chk (.*);

// ----- tb/tb.sv -----
// Testbench for multirate_polyphase_fir_chain: directed and random words, checked
// against a behavioural predictor of the decimate/kernel/interpolate chain.
// Depends on mpfc_pkg and the RTL of the chain.
`timescale 1ns / 1ps

module tb;
   import mpfc_pkg::*;

   localparam int PTAPS = 32;
   localparam int KTAPS = 64;
   localparam int KBASE = NUM_PHASES * PTAPS;
   localparam int NCOEF = KBASE + KTAPS;
   localparam int IBASE = NUM_PHASES * PTAPS;       // interpolator lines in tap_line
   localparam int KLINE = 2 * NUM_PHASES * PTAPS;   // kernel line in tap_line
   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_opcode;
   logic signed [15:0] req_data_word;
   logic [2:0]         req_coef_bank;
   logic [5:0]         req_coef_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_out_sample;

   multirate_polyphase_fir_chain uut (.*);

   // predictor state
   logic signed [15:0] coef_mem [NCOEF];
   logic signed [15:0] tap_line [KLINE + KTAPS];
   logic signed [15:0] partials [3];
   logic signed [15:0] kern_hold;
   logic [1:0]         dec_ph, int_ph;
   logic signed [15:0] expected_samples [$];

   int  errors, samples_in, coefs_in, results_seen, idle_cycles;
   bit  idle_on;
   bit  hold_req;
   int  hold_cnt;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic signed [15:0] fir_push(int lbase, int cbase, int n,
                                                   logic signed [15:0] x);
      logic [31:0]        acc;
      logic signed [31:0] prod;
      for (int i = 0; i < n - 1; i++) tap_line[lbase + i] = tap_line[lbase + i + 1];
      tap_line[lbase + n - 1] = x;
      acc = '0;
      for (int i = 0; i < n; i++) begin
         prod = tap_line[lbase + n - 1 - i] * coef_mem[cbase + i];
         acc  = acc + (prod << 1);
      end
      return acc[31:16];
   endfunction

   task automatic predict_word(logic op, logic signed [15:0] d, logic [2:0] bank,
                               logic [5:0] idx);
      logic signed [15:0] y, r, s;
      logic [1:0]         dbank;
      if (op == OP_COEF) begin
         coefs_in++;
         if (bank < NUM_PHASES && idx < PTAPS) coef_mem[bank * PTAPS + idx] = d;
         else if (bank == KERNEL_BANK) coef_mem[KBASE + idx] = d;
      end else begin
         samples_in++;
         case (dec_ph)
            2'd0: dbank = 2'd0;
            2'd1: dbank = 2'd3;
            2'd2: dbank = 2'd2;
            default: dbank = 2'd1;
         endcase
         y = fir_push(dec_ph * PTAPS, dbank * PTAPS, PTAPS, d);
         if (dec_ph == 2'd0) begin
            s = y + partials[0] + partials[1] + partials[2];
            kern_hold = fir_push(KLINE, KBASE, KTAPS, s);
         end else begin
            partials[dec_ph - 1] = y;
         end
         dec_ph = dec_ph + 2'd1;
         r = fir_push(IBASE + int_ph * PTAPS, int_ph * PTAPS, PTAPS, kern_hold);
         int_ph = int_ph + 2'd1;
         expected_samples.push_back(r <<< 2);
      end
   endtask

   task automatic report_mismatch(string what, logic signed [15:0] got,
                                  logic signed [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sender: valid stays high between back-to-back words
   task automatic send_word(logic op, logic signed [15:0] d, logic [2:0] bank,
                            logic [5:0] idx);
      while (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_data_word  <= d;
      req_coef_bank  <= bank;
      req_coef_index <= idx;
      do @(posedge clock); while (req_stall);
      predict_word(op, d, bank, idx);
   endtask

   task automatic send_sample(logic signed [15:0] d);
      send_word(OP_SAMPLE, d, 3'($urandom_range(7)), 6'($urandom_range(63)));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // mode 0 random, 1 most negative, 2 most positive, 3 small
   task automatic load_coefs(int mode);
      logic signed [15:0] c;
      for (int b = 0; b <= KERNEL_BANK; b++)
         for (int i = 0; i < (b == KERNEL_BANK ? KTAPS : PTAPS); i++) begin
            case (mode)
               1: c = 16'sh8000;
               2: c = 16'sh7fff;
               3: c = $signed(16'($urandom_range(4095))) - 16'sd2048;
               default: c = 16'($urandom);
            endcase
            send_word(OP_COEF, c, 3'(b), 6'(i));
         end
   endtask

   task automatic test_extremes;
      logic signed [15:0] vals [6];
      vals = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555};
      load_coefs(2);
      foreach (vals[i]) send_sample(vals[i]);
      drain();
      load_coefs(1);
      foreach (vals[i]) send_sample(vals[i]);
      // writes that must be ignored, then one to the top kernel tap that is taken
      send_word(OP_COEF, 16'sh1234, 3'd5, 6'd0);
      send_word(OP_COEF, 16'sh1234, 3'd6, 6'd3);
      send_word(OP_COEF, 16'sh1234, 3'd7, 6'd63);
      send_word(OP_COEF, 16'sh1234, 3'd0, 6'd32);
      send_word(OP_COEF, 16'sh1234, 3'd3, 6'd63);
      send_word(OP_COEF, 16'sh4321, 3'd4, 6'd63);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      drain();
   endtask

   task automatic test_random(int n);
      load_coefs(3);
      for (int i = 0; i < n; i++) begin
         idle_on = !(i >= n / 3 && i < n / 2);
         if ($urandom_range(99) < 12)
            send_word(OP_COEF, 16'($urandom), 3'($urandom_range(7)),
                      6'($urandom_range(63)));
         else
            send_sample(16'($urandom));
      end
      idle_on = 1'b1;
      drain();
   endtask

   task automatic test_backpressure;
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) send_sample(16'($urandom));
      drain();
   endtask

   task automatic test_pause;
      load_coefs(0);
      for (int i = 0; i < 20; i++) send_sample(16'($urandom));
      drain();
      for (int i = 0; i < 20; i++) send_sample(16'($urandom));
      drain();
   endtask

   // receiver
   always @(posedge clock) begin
      if (hold_req && hold_cnt == 0) begin
         hold_req = 1'b0;
         hold_cnt <= 800;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 16);
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected out_sample", rsp_out_sample, '0);
         end else begin
            if (rsp_out_sample !== expected_samples[0])
               report_mismatch("out_sample", rsp_out_sample, expected_samples[0]);
            void'(expected_samples.pop_front());
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_SAMPLE;
      req_data_word  <= '0;
      req_coef_bank  <= '0;
      req_coef_index <= '0;
      rsp_stall      <= 1'b0;
      hold_req = 1'b0;
      hold_cnt = 0;
      idle_on = 1'b1;
      errors = 0;
      samples_in = 0;
      coefs_in = 0;
      results_seen = 0;
      idle_cycles = 0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (tap_line[i]) tap_line[i] = '0;
      partials = '{default: '0};
      kern_hold = '0;
      dec_ph = '0;
      int_ph = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_random(240);
      test_backpressure();
      test_pause();
      if (expected_samples.size() != 0) begin
         $display("%0d output words never arrived", expected_samples.size());
         errors++;
      end
      $display("covered %0d samples and %0d coefficient words, %0d outputs checked",
               samples_in, coefs_in, results_seen);
      $display("with extreme, random and small coefficient sets, ignored writes and stalls");
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
